// ----- hw/rtl/sjfq_pkg.sv -----
package sjfq_pkg;

    localparam int LEN_W = 16;
    localparam int CNT_OUT_W = 5;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    // Broadcast command for the cell row
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_EXTRACT
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [LEN_W-1:0] length;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/sjfq_cell.sv -----
module sjfq_cell (
    input  logic                          i_clk,
    input  sjfq_pkg::t_cell_ctl           i_ctl,
    input  logic                          i_occupied,
    input  logic                          i_left_greater,
    input  logic [sjfq_pkg::LEN_W-1:0]    i_left_len,
    input  logic [sjfq_pkg::LEN_W-1:0]    i_right_len,
    output logic                          o_greater,
    output logic [sjfq_pkg::LEN_W-1:0]    o_len
);
    import sjfq_pkg::*;

    logic [LEN_W-1:0] r_len;

    // Empty slots count as larger than any job; strict compare keeps ties in arrival order
    assign o_greater = !i_occupied || (r_len > i_ctl.length);
    assign o_len     = r_len;

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            CELL_INSERT: begin
                if (o_greater) begin
                    r_len <= i_left_greater ? i_left_len : i_ctl.length;
                end
            end
            CELL_EXTRACT: begin
                r_len <= i_right_len;
            end
            CELL_HOLD: begin
                r_len <= r_len;
            end
            default: begin
                r_len <= r_len;
            end
        endcase
    end

endmodule

// ----- hw/rtl/shortest_job_first_queue_top.sv -----
// Channel  | Dir | tdata (low bit up)                          | tuser
// ---------+-----+---------------------------------------------+--------------------
// s (job)  | in  | [15:0] job_length                           | [0] func (1 = extract)
// m (res)  | out | [15:0] removed_length, [20:16] count, pad 0 | [1:0] status
//
// One transfer per cycle on the input while o_s_tready is high: each cell holds one job, the row is kept
// sorted by length (ties in arrival order), and all cells compare and shift at once.
// The result sits in an output register from the cycle after its input transfer.
// Reset clears the job count and the output valid; cell contents need no reset.
// o_s_tready drops only while a result is held and i_m_tready is low.
module shortest_job_first_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // [15:0] job_length
    input  logic [0:0]  i_s_tuser,  // [0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // [15:0] removed_length, [20:16] count
    output logic [1:0]  o_m_tuser   // [1:0] status
);
    import sjfq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]     r_count, n_count;
    logic              r_out_valid;
    logic [LEN_W-1:0]  r_out_removed, n_removed;
    logic [STATUS_W-1:0] r_out_status, n_status;
    logic [CNT_OUT_W-1:0] r_out_count;

    t_cell_ctl         cell_ctl;
    logic              s_fire;
    logic              is_full, is_empty;
    logic [LEN_W-1:0]  cell_len [DEPTH];
    logic              cell_gt  [DEPTH];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign is_full    = (r_count == CW'(DEPTH));
    assign is_empty   = (r_count == '0);

    // Decode the transfer into a row command; full and empty are refused here
    always_comb begin
        cell_ctl.op     = CELL_HOLD;
        cell_ctl.length = i_s_tdata[LEN_W-1:0];
        n_count         = r_count;
        n_status        = STATUS_OK;
        n_removed       = '0;
        if (s_fire) begin
            if (i_s_tuser[0] == FUNC_INSERT) begin
                if (is_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    cell_ctl.op = CELL_INSERT;
                    n_count     = r_count + 1'b1;
                end
            end else begin
                if (is_empty) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    cell_ctl.op = CELL_EXTRACT;
                    n_removed   = cell_len[0];   // head cell holds the shortest, oldest job
                    n_count     = r_count - 1'b1;
                end
            end
        end
    end

    // Cell row: left neighbor feeds inserts, right neighbor feeds extracts
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic              left_gt;
        logic [LEN_W-1:0]  left_len;
        logic [LEN_W-1:0]  right_len;

        if (gi == 0) begin : g_first
            assign left_gt  = 1'b0;
            assign left_len = '0;
        end else begin : g_mid
            assign left_gt  = cell_gt[gi-1];
            assign left_len = cell_len[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign right_len = '0;
        end else begin : g_inner
            assign right_len = cell_len[gi+1];
        end

        sjfq_cell u_cell (
            .i_clk          (i_clk),
            .i_ctl          (cell_ctl),
            .i_occupied     (r_count > CW'(gi)),
            .i_left_greater (left_gt),
            .i_left_len     (left_len),
            .i_right_len    (right_len),
            .o_greater      (cell_gt[gi]),
            .o_len          (cell_len[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (s_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_removed <= n_removed;
            r_out_status  <= n_status;
            r_out_count   <= CNT_OUT_W'(n_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_count, r_out_removed};
    assign o_m_tuser  = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("job count above depth");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && i_s_tuser[0] == FUNC_INSERT && is_full
        |=> r_out_status == STATUS_FULL && r_count == CW'(DEPTH))
        else $error("insert into full queue not refused");

    a_extract_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && i_s_tuser[0] == FUNC_EXTRACT && !is_empty
        |=> r_count == $past(r_count) - 1'b1 && r_out_status == STATUS_OK)
        else $error("extract did not lower the count");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CW'(2) |-> cell_len[0] <= cell_len[1])
        else $error("cell row head out of order");

endmodule
